FILE: rtl/dpia_pkg.sv
// ----------------------------------------------------------------------------
// Dual-pool id allocator package
// Shared widths, defaults, operation and status codes, controller state type.
// ----------------------------------------------------------------------------
package dpia_pkg;

    localparam int ID_W     = 9;
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 3;
    localparam int TRK_W    = 8;
    localparam int LIMIT_W  = 9;
    localparam int ID_MAX   = 511;

    localparam int LOW_POOL_CAP_DEF  = 256;
    localparam int HIGH_POOL_CAP_DEF = 256;

    // APB register map: one 32-bit register at byte address 0
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_UNSYNC_LIMIT = 1'b0;
    localparam logic [LIMIT_W-1:0]   LIMIT_RESET      = 9'd256;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_FETCH_LOW  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FETCH_HIGH = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DESTROY    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RELEASE    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SOFT_RESET = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_LOW_EMPTY   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_HIGH_EMPTY  = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_NOT_TRACKED = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_STACK_FULL  = 3'd4;

    localparam logic [TRK_W-1:0] TRK_SAT = '1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_POP,
        ST_EXEC
    } ctrl_state_t;

endpackage

FILE: rtl/dpia_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module dpia_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/dpia_cfg.sv
// ----------------------------------------------------------------------------
// Dual-pool id allocator configuration
// APB register file holding the pool split, and the clamped limit it yields.
// ----------------------------------------------------------------------------
module dpia_cfg #(
    parameter int LOW_POOL_CAP = dpia_pkg::LOW_POOL_CAP_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dpia_pkg::PADDR_W-1:0]   paddr,
    input  logic [dpia_pkg::PDATA_W-1:0]   pwdata,
    output logic [dpia_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    output logic [dpia_pkg::LIMIT_W-1:0]   eff_limit
);

    import dpia_pkg::*;

    logic [LIMIT_W-1:0]   limit_reg;
    logic [LIMIT_W-1:0]   limit_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_comb
    begin
        limit_next = limit_reg;
        if (wr_en && (reg_idx == REG_UNSYNC_LIMIT))
        begin
            limit_next = pwdata[LIMIT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    assign prdata = (reg_idx == REG_UNSYNC_LIMIT) ? PDATA_W'(limit_reg) : '0;

    // zero acts as one, anything above the low pool capacity as the capacity
    always_comb
    begin
        if (limit_reg == '0)
        begin
            eff_limit = LIMIT_W'(1);
        end
        else if (int'(limit_reg) > LOW_POOL_CAP)
        begin
            eff_limit = LIMIT_W'(LOW_POOL_CAP);
        end
        else
        begin
            eff_limit = limit_reg;
        end
    end

endmodule

FILE: rtl/dpia_ctrl.sv
// ----------------------------------------------------------------------------
// Dual-pool id allocator controller
// Sequencer doing read-modify-write on the free-stack and tracked-count RAMs.
// ----------------------------------------------------------------------------
module dpia_ctrl #(
    parameter int LOW_POOL_CAP  = dpia_pkg::LOW_POOL_CAP_DEF,
    parameter int HIGH_POOL_CAP = dpia_pkg::HIGH_POOL_CAP_DEF,
    localparam int STK_DEPTH    = LOW_POOL_CAP + HIGH_POOL_CAP,
    localparam int STK_AW       = $clog2(STK_DEPTH),
    localparam int TRK_AW       = $clog2(LOW_POOL_CAP)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [dpia_pkg::LIMIT_W-1:0]    eff_limit,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  logic [dpia_pkg::MODE_W-1:0]     mode,
    input  logic [dpia_pkg::ID_W-1:0]       body_id,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output logic [dpia_pkg::ID_W-1:0]       result_id,
    output logic [dpia_pkg::STATUS_W-1:0]   status,
    output logic                            is_low_pool,
    output logic                            stk_we,
    output logic [STK_AW-1:0]               stk_waddr,
    output logic [dpia_pkg::ID_W-1:0]       stk_wdata,
    output logic                            stk_re,
    output logic [STK_AW-1:0]               stk_raddr,
    input  logic [dpia_pkg::ID_W-1:0]       stk_rdata,
    output logic                            trk_we,
    output logic [TRK_AW-1:0]               trk_waddr,
    output logic [dpia_pkg::TRK_W-1:0]      trk_wdata,
    output logic                            trk_re,
    output logic [TRK_AW-1:0]               trk_raddr,
    input  logic [dpia_pkg::TRK_W-1:0]      trk_rdata
);

    import dpia_pkg::*;

    localparam int LCNT_W = $clog2(LOW_POOL_CAP + 1);
    localparam int HCNT_W = $clog2(HIGH_POOL_CAP + 1);

    ctrl_state_t state_reg, state_next;

    logic [TRK_AW-1:0]   clr_idx_reg, clr_idx_next;
    logic [LCNT_W-1:0]   low_cnt_reg, low_cnt_next;
    logic [HCNT_W-1:0]   high_cnt_reg, high_cnt_next;
    logic [ID_W-1:0]     low_gen_reg, low_gen_next;
    logic [ID_W-1:0]     high_gen_reg, high_gen_next;

    // operation held between accept and execute
    logic [MODE_W-1:0]   op_mode_reg;
    logic [ID_W-1:0]     op_body_reg;
    logic                op_pop_reg;
    logic                op_empty_reg;
    logic                op_untracked_reg;
    logic [ID_W-1:0]     op_gen_id_reg;

    logic                rsp_valid_reg, rsp_valid_next;
    logic [ID_W-1:0]     rsp_id_reg;
    logic [STATUS_W-1:0] rsp_status_reg;
    logic                rsp_low_reg;

    logic                accept;
    logic                exec_go;

    logic                low_pop, low_empty, high_pop, high_empty, body_untracked;
    logic                acc_pop, acc_empty;
    logic [ID_W-1:0]     acc_gen_id;

    logic [ID_W-1:0]     exec_id;
    logic [STATUS_W-1:0] exec_status;
    logic                exec_trk_we;
    logic [TRK_AW-1:0]   exec_trk_addr;
    logic [TRK_W-1:0]    exec_trk_data;
    logic                push_en;
    logic                push_low;

    assign accept  = req_valid && req_ready;
    assign exec_go = (state_reg == ST_EXEC) && (!rsp_valid_reg || rsp_ready);

    // ---- decisions taken at accept, from registered counters ----
    assign low_pop        = (low_cnt_reg != '0);
    assign low_empty      = (low_gen_reg >= eff_limit);
    assign high_pop       = (high_cnt_reg != '0);
    assign high_empty     = (int'(high_gen_reg) >= HIGH_POOL_CAP) ||
                            (({1'b0, eff_limit} + {1'b0, high_gen_reg}) > (ID_W + 1)'(ID_MAX));
    assign body_untracked = (int'(body_id) >= LOW_POOL_CAP);

    always_comb
    begin
        acc_pop    = 1'b0;
        acc_empty  = 1'b0;
        acc_gen_id = low_gen_reg;
        unique case (mode)
            MODE_FETCH_LOW:
            begin
                acc_pop    = low_pop;
                acc_empty  = !low_pop && low_empty;
                acc_gen_id = low_gen_reg;
            end
            MODE_FETCH_HIGH:
            begin
                acc_pop    = high_pop;
                acc_empty  = !high_pop && high_empty;
                acc_gen_id = eff_limit + high_gen_reg;
            end
            default:
            begin
                acc_pop = 1'b0;
            end
        endcase
    end

    // ---- next state ----
    always_comb
    begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == TRK_AW'(LOW_POOL_CAP - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (mode == MODE_FETCH_LOW && acc_pop) ? ST_POP : ST_EXEC;
                end
            end
            ST_POP:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // ---- outputs of the sequencer: handshake, RAM reads, tracked writes ----
    always_comb
    begin
        req_ready = 1'b0;
        stk_re    = 1'b0;
        stk_raddr = '0;
        trk_re    = 1'b0;
        trk_raddr = '0;
        trk_we    = 1'b0;
        trk_waddr = exec_trk_addr;
        trk_wdata = exec_trk_data;
        unique case (state_reg)
            ST_CLEAR:
            begin
                trk_we    = 1'b1;
                trk_waddr = clr_idx_reg;
                trk_wdata = '0;
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (mode == MODE_FETCH_LOW)
                begin
                    stk_re    = req_valid && low_pop;
                    stk_raddr = STK_AW'(low_cnt_reg - 1'b1);
                    trk_re    = req_valid && !low_pop && !low_empty;
                    trk_raddr = TRK_AW'(low_gen_reg);
                end
                else if (mode == MODE_FETCH_HIGH)
                begin
                    stk_re    = req_valid && high_pop;
                    stk_raddr = STK_AW'(LOW_POOL_CAP) + STK_AW'(high_cnt_reg - 1'b1);
                end
                else if (mode == MODE_DESTROY)
                begin
                    trk_re    = req_valid && !body_untracked;
                    trk_raddr = TRK_AW'(body_id);
                end
            end
            ST_POP:
            begin
                // reused id has just come out of the stack
                trk_re    = 1'b1;
                trk_raddr = TRK_AW'(stk_rdata);
            end
            ST_EXEC:
            begin
                trk_we = exec_go && exec_trk_we;
            end
            default:
            begin
                trk_we = 1'b0;
            end
        endcase
    end

    // ---- execute: result, counter updates, RAM writes ----
    assign push_low = (op_body_reg < eff_limit);

    always_comb
    begin
        exec_id       = op_body_reg;
        exec_status   = STAT_OK;
        exec_trk_we   = 1'b0;
        exec_trk_addr = TRK_AW'(op_body_reg);
        exec_trk_data = trk_rdata - 1'b1;
        push_en       = 1'b0;
        low_cnt_next  = low_cnt_reg;
        high_cnt_next = high_cnt_reg;
        low_gen_next  = low_gen_reg;
        high_gen_next = high_gen_reg;
        stk_waddr     = STK_AW'(low_cnt_reg);
        stk_wdata     = op_body_reg;

        unique case (op_mode_reg)
            MODE_FETCH_LOW:
            begin
                if (op_pop_reg)
                begin
                    exec_id      = stk_rdata;
                    low_cnt_next = low_cnt_reg - 1'b1;
                end
                else if (op_empty_reg)
                begin
                    exec_id     = '0;
                    exec_status = STAT_LOW_EMPTY;
                end
                else
                begin
                    exec_id      = op_gen_id_reg;
                    low_gen_next = low_gen_reg + 1'b1;
                end
                exec_trk_we   = !op_empty_reg && (int'(exec_id) < LOW_POOL_CAP);
                exec_trk_addr = TRK_AW'(exec_id);
                exec_trk_data = (trk_rdata == TRK_SAT) ? TRK_SAT : trk_rdata + 1'b1;
            end
            MODE_FETCH_HIGH:
            begin
                if (op_pop_reg)
                begin
                    exec_id       = stk_rdata;
                    high_cnt_next = high_cnt_reg - 1'b1;
                end
                else if (op_empty_reg)
                begin
                    exec_id     = '0;
                    exec_status = STAT_HIGH_EMPTY;
                end
                else
                begin
                    exec_id       = op_gen_id_reg;
                    high_gen_next = high_gen_reg + 1'b1;
                end
            end
            MODE_DESTROY, MODE_RELEASE:
            begin
                if (op_mode_reg == MODE_DESTROY && (op_untracked_reg || trk_rdata == '0))
                begin
                    exec_status = STAT_NOT_TRACKED;
                end
                else if (push_low)
                begin
                    if (int'(low_cnt_reg) >= LOW_POOL_CAP)
                    begin
                        exec_status = STAT_STACK_FULL;
                    end
                    else
                    begin
                        push_en      = 1'b1;
                        stk_waddr    = STK_AW'(low_cnt_reg);
                        low_cnt_next = low_cnt_reg + 1'b1;
                    end
                end
                else
                begin
                    if (int'(high_cnt_reg) >= HIGH_POOL_CAP)
                    begin
                        exec_status = STAT_STACK_FULL;
                    end
                    else
                    begin
                        push_en       = 1'b1;
                        stk_waddr     = STK_AW'(LOW_POOL_CAP) + STK_AW'(high_cnt_reg);
                        high_cnt_next = high_cnt_reg + 1'b1;
                    end
                end
                exec_trk_we = (op_mode_reg == MODE_DESTROY) && push_en;
            end
            MODE_SOFT_RESET:
            begin
                low_cnt_next  = '0;
                high_cnt_next = '0;
                low_gen_next  = '0;
                high_gen_next = '0;
            end
            default:
            begin
                exec_status = STAT_OK;
            end
        endcase
    end

    assign stk_we = exec_go && push_en;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (exec_go)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // ---- registers ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            low_cnt_reg   <= '0;
            high_cnt_reg  <= '0;
            low_gen_reg   <= '0;
            high_gen_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            rsp_valid_reg <= rsp_valid_next;
            if (exec_go)
            begin
                low_cnt_reg  <= low_cnt_next;
                high_cnt_reg <= high_cnt_next;
                low_gen_reg  <= low_gen_next;
                high_gen_reg <= high_gen_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_mode_reg      <= mode;
            op_body_reg      <= body_id;
            op_pop_reg       <= acc_pop;
            op_empty_reg     <= acc_empty;
            op_untracked_reg <= body_untracked;
            op_gen_id_reg    <= acc_gen_id;
        end
        if (exec_go)
        begin
            rsp_id_reg     <= exec_id;
            rsp_status_reg <= exec_status;
            rsp_low_reg    <= (exec_id < eff_limit);
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign result_id   = rsp_id_reg;
    assign status      = rsp_status_reg;
    assign is_low_pool = rsp_low_reg;

    // ---- assertions ----
    a_low_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(low_cnt_reg) <= LOW_POOL_CAP)
        else $error("low free count above capacity");

    a_high_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(high_cnt_reg) <= HIGH_POOL_CAP)
        else $error("high free count above capacity");

    a_stk_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(stk_we && stk_re))
        else $error("stack read and write in the same cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_POP || state_reg == ST_EXEC))
        else $error("accepted item not taken into execution");

    a_empty_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_go && (exec_status == STAT_LOW_EMPTY || exec_status == STAT_HIGH_EMPTY))
        |=> (rsp_id_reg == '0))
        else $error("exhausted pool returned a nonzero id");

endmodule

FILE: rtl/dual_pool_id_allocator_unit.sv
// ----------------------------------------------------------------------------
// Dual-pool id allocator
// Hands out and takes back identifiers from a low (tracked) and a high pool.
// ----------------------------------------------------------------------------
// Identifiers below unsync_limit form the low pool, those at or above it the
// high pool. A fetch pops the most recently freed id of its pool, or else
// takes the next fresh value (the high pool adds the limit to its counter).
// Low fetches bump a per-id tracked count (saturating at 255); a destroy
// frees an id only while its count is nonzero, a release frees it always,
// onto the stack picked by comparing the id with the limit. Soft reset
// empties both stacks and counters but keeps the tracked counts. Every item
// gives exactly one result item, with status reporting an empty pool, an
// untracked id or a full stack. An accepted item moves on to the execute
// state, where its result is registered once the output register is free;
// a low fetch that reuses a freed id passes through a pop state first, as
// the stack read must return before the tracked count of that id can be
// read, both RAMs having registered reads. One item is in flight at a
// time; the next is taken as soon as the previous has been written back,
// even while its result still waits in the output register. After reset
// the tracked-count RAM is swept to zero, one entry per cycle, over all
// LOW_POOL_CAP entries (256 by default); req_ready stays low meanwhile
// while APB writes are taken as usual. unsync_limit is used as 1 when
// written 0 and clamped to LOW_POOL_CAP; change it only while the block is
// idle.
// ----------------------------------------------------------------------------
module dual_pool_id_allocator_unit #(
    parameter int LOW_POOL_CAP  = dpia_pkg::LOW_POOL_CAP_DEF,
    parameter int HIGH_POOL_CAP = dpia_pkg::HIGH_POOL_CAP_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // APB configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dpia_pkg::PADDR_W-1:0]    paddr,
    input  logic [dpia_pkg::PDATA_W-1:0]    pwdata,
    output logic [dpia_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready,
    // request items
    input  logic                            req_valid,
    output logic                            req_ready,
    input  logic [dpia_pkg::MODE_W-1:0]     mode,
    input  logic [dpia_pkg::ID_W-1:0]       body_id,
    // result items
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output logic [dpia_pkg::ID_W-1:0]       result_id,
    output logic [dpia_pkg::STATUS_W-1:0]   status,
    output logic                            is_low_pool
);

    import dpia_pkg::*;

    // both free stacks share one RAM: low stack first, high stack above it
    localparam int STK_DEPTH = LOW_POOL_CAP + HIGH_POOL_CAP;
    localparam int STK_AW    = $clog2(STK_DEPTH);
    localparam int TRK_AW    = $clog2(LOW_POOL_CAP);

    logic [LIMIT_W-1:0] eff_limit;

    logic               stk_we;
    logic [STK_AW-1:0]  stk_waddr;
    logic [ID_W-1:0]    stk_wdata;
    logic               stk_re;
    logic [STK_AW-1:0]  stk_raddr;
    logic [ID_W-1:0]    stk_rdata;

    logic               trk_we;
    logic [TRK_AW-1:0]  trk_waddr;
    logic [TRK_W-1:0]   trk_wdata;
    logic               trk_re;
    logic [TRK_AW-1:0]  trk_raddr;
    logic [TRK_W-1:0]   trk_rdata;

    // register file and limit clamp
    dpia_cfg #(
        .LOW_POOL_CAP (LOW_POOL_CAP)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .eff_limit (eff_limit)
    );

    // sequencer: accept, read, modify, write back, present result
    dpia_ctrl #(
        .LOW_POOL_CAP  (LOW_POOL_CAP),
        .HIGH_POOL_CAP (HIGH_POOL_CAP)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .eff_limit   (eff_limit),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .mode        (mode),
        .body_id     (body_id),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .result_id   (result_id),
        .status      (status),
        .is_low_pool (is_low_pool),
        .stk_we      (stk_we),
        .stk_waddr   (stk_waddr),
        .stk_wdata   (stk_wdata),
        .stk_re      (stk_re),
        .stk_raddr   (stk_raddr),
        .stk_rdata   (stk_rdata),
        .trk_we      (trk_we),
        .trk_waddr   (trk_waddr),
        .trk_wdata   (trk_wdata),
        .trk_re      (trk_re),
        .trk_raddr   (trk_raddr),
        .trk_rdata   (trk_rdata)
    );

    // free stacks; contents undefined until pushed
    dpia_ram #(
        .WIDTH (ID_W),
        .DEPTH (STK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // tracked counts, cleared by the sweep after reset
    dpia_ram #(
        .WIDTH (TRK_W),
        .DEPTH (LOW_POOL_CAP)
    ) u_track_ram (
        .clk   (clk),
        .we    (trk_we),
        .waddr (trk_waddr),
        .wdata (trk_wdata),
        .re    (trk_re),
        .raddr (trk_raddr),
        .rdata (trk_rdata)
    );

endmodule

FILE: tb/sv/tb_dual_pool_id_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual-pool id allocator testbench
// Drives directed and random request items through the allocator, keeps its
// own model of both pools, both free stacks and the tracked counts, and
// checks every result item field by field in the order the items went in.
// ----------------------------------------------------------------------------
module tb_dual_pool_id_allocator_unit;
    import dpia_pkg::*;

    localparam int LOW_CAP     = LOW_POOL_CAP_DEF;
    localparam int HIGH_CAP    = HIGH_POOL_CAP_DEF;
    // clear sweep and the long receiver hold-off both fit well inside
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [ID_W-1:0]     rid;
        logic [STATUS_W-1:0] stat;
        logic                low;
    } alloc_result_t;

    // ------------------------------------------------------------------------
    // DUT signals: every input starts at a known value
    // ------------------------------------------------------------------------
    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [PADDR_W-1:0]  paddr     = '0;
    logic [PDATA_W-1:0]  pwdata    = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                req_valid = 1'b0;
    logic                req_ready;
    logic [MODE_W-1:0]   mode      = '0;
    logic [ID_W-1:0]     body_id   = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    logic [ID_W-1:0]     result_id;
    logic [STATUS_W-1:0] status;
    logic                is_low_pool;

    dual_pool_id_allocator_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .mode        (mode),
        .body_id     (body_id),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .result_id   (result_id),
        .status      (status),
        .is_low_pool (is_low_pool)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Allocator model: limit register, free stacks, fresh counters, tracked
    // counts. Updated once per accepted item, in acceptance order.
    // ------------------------------------------------------------------------
    logic [LIMIT_W-1:0] limit_reg = LIMIT_RESET;
    logic [ID_W-1:0]    low_free  [LOW_CAP];
    logic [ID_W-1:0]    high_free [HIGH_CAP];
    int                 low_free_cnt  = 0;
    int                 high_free_cnt = 0;
    int                 low_next      = 0;
    int                 high_next     = 0;
    logic [TRK_W-1:0]   trk_count [LOW_CAP];

    // results still owed by the block, oldest first
    alloc_result_t      pending_results [$];

    int error_count   = 0;
    int stall_cycles  = 0;
    // idling knobs, in percent per item / per cycle
    int tx_gap_pct    = 0;
    int rx_stall_pct  = 0;
    // long receiver hold-off, picked up by the receiver process
    int rx_hold_request = 0;
    int rx_stall_left   = 0;

    // freed id goes onto the stack picked by the limit at the time of freeing
    function automatic logic [STATUS_W-1:0] push_free_id(input logic [ID_W-1:0] id,
                                                         input int lim);
        if (id < lim)
        begin
            if (low_free_cnt >= LOW_CAP)
                return STAT_STACK_FULL;
            low_free[low_free_cnt] = id;
            low_free_cnt++;
        end
        else
        begin
            if (high_free_cnt >= HIGH_CAP)
                return STAT_STACK_FULL;
            high_free[high_free_cnt] = id;
            high_free_cnt++;
        end
        return STAT_OK;
    endfunction

    function automatic alloc_result_t predict_alloc(input logic [MODE_W-1:0] m,
                                                    input logic [ID_W-1:0] id);
        alloc_result_t r;
        int            lim;
        // zero reads as one, anything above the pool size is clamped
        lim = (limit_reg == '0) ? 1 : ((limit_reg > LOW_CAP) ? LOW_CAP : int'(limit_reg));
        r.rid  = id;
        r.stat = STAT_OK;
        case (m)
            MODE_FETCH_LOW:
            begin
                if (low_free_cnt > 0)
                begin
                    low_free_cnt--;
                    r.rid = low_free[low_free_cnt];
                end
                else if (low_next >= lim)
                begin
                    r.rid  = '0;
                    r.stat = STAT_LOW_EMPTY;
                end
                else
                begin
                    r.rid = ID_W'(low_next);
                    low_next++;
                end
                if (r.stat == STAT_OK && r.rid < LOW_CAP && trk_count[r.rid] != TRK_SAT)
                    trk_count[r.rid]++;
            end
            MODE_FETCH_HIGH:
            begin
                if (high_free_cnt > 0)
                begin
                    high_free_cnt--;
                    r.rid = high_free[high_free_cnt];
                end
                else if (high_next >= HIGH_CAP || lim + high_next > ID_MAX)
                begin
                    r.rid  = '0;
                    r.stat = STAT_HIGH_EMPTY;
                end
                else
                begin
                    r.rid = ID_W'(lim + high_next);
                    high_next++;
                end
            end
            MODE_DESTROY:
            begin
                if (id >= LOW_CAP || trk_count[id] == '0)
                    r.stat = STAT_NOT_TRACKED;
                else
                begin
                    // a full stack leaves the tracked count alone
                    r.stat = push_free_id(id, lim);
                    if (r.stat == STAT_OK)
                        trk_count[id]--;
                end
            end
            MODE_RELEASE:
                r.stat = push_free_id(id, lim);
            MODE_SOFT_RESET:
            begin
                low_next      = 0;
                high_next     = 0;
                low_free_cnt  = 0;
                high_free_cnt = 0;
            end
            default:
                ;
        endcase
        r.low = (r.rid < lim);
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    endfunction

    // ------------------------------------------------------------------------
    // Result side: checks each accepted result item, then decides ready for
    // the next cycle (random stalls, or a long hold-off on request)
    // ------------------------------------------------------------------------
    function automatic void check_alloc_result();
        alloc_result_t want;
        if (pending_results.size() == 0)
        begin
            $display("%0t: unexpected result item: id %0d status %0d low %0b",
                     $time, result_id, status, is_low_pool);
            error_count++;
            return;
        end
        want = pending_results.pop_front();
        if (result_id !== want.rid)
        begin
            $display("%0t: result_id expected %0d, got %0d", $time, want.rid, result_id);
            error_count++;
        end
        if (status !== want.stat)
        begin
            $display("%0t: status expected %0d, got %0d", $time, want.stat, status);
            error_count++;
        end
        if (is_low_pool !== want.low)
        begin
            $display("%0t: is_low_pool expected %0b, got %0b", $time, want.low, is_low_pool);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            check_alloc_result();
        if (rx_hold_request > 0)
        begin
            rx_stall_left   = rx_hold_request;
            rx_hold_request = 0;
        end
        else if (rx_stall_left == 0 && $urandom_range(0, 99) < rx_stall_pct)
            rx_stall_left = gap_len();
        rsp_ready <= (rx_stall_left == 0);
        if (rx_stall_left > 0)
            rx_stall_left--;
    end

    // watchdog: any handshake or APB transfer counts as progress
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    // Valid is left high after acceptance; only a gap or a drain lowers it, so
    // back-to-back items never see valid dropped and raised in one step.
    task automatic send_item(input logic [MODE_W-1:0] m, input logic [ID_W-1:0] id,
                             output alloc_result_t res);
        if (tx_gap_pct > 0 && $urandom_range(0, 99) < tx_gap_pct)
        begin
            req_valid <= 1'b0;
            repeat (gap_len()) @(posedge clk);
        end
        req_valid <= 1'b1;
        mode      <= m;
        body_id   <= id;
        do
            @(posedge clk);
        while (!req_ready);
        res = predict_alloc(m, id);
        pending_results.insert(pending_results.size(), res);
    endtask

    // stop offering, let every owed result come back, then a few spare cycles
    task automatic wait_idle();
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // write the limit over APB (junk in the unused upper bits), then read it back
    task automatic program_limit(input logic [LIMIT_W-1:0] value);
        logic [PDATA_W-1:0] wdata;
        logic [PDATA_W-1:0] rdata;
        wait_idle();
        wdata = PDATA_W'($urandom());
        wdata[LIMIT_W-1:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_UNSYNC_LIMIT, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        limit_reg = value;
        // back-to-back read: psel stays up, new setup phase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rdata !== PDATA_W'(value))
        begin
            $display("%0t: unsync_limit read expected %0d, got %0d", $time, value, rdata);
            error_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_register_access();
        program_limit('0);
        program_limit(LIMIT_W'(ID_MAX));
        program_limit(LIMIT_RESET);
    endtask

    // every operation once or twice at the default limit
    task automatic test_basic_ops();
        alloc_result_t res;
        send_item(MODE_SOFT_RESET, ID_W'(ID_MAX), res);
        send_item(MODE_FETCH_LOW, '0, res);
        send_item(MODE_FETCH_LOW, ID_W'(ID_MAX), res);      // fetch ignores body_id
        send_item(MODE_FETCH_HIGH, '0, res);
        send_item(MODE_FETCH_HIGH, ID_W'(ID_MAX), res);
        send_item(MODE_DESTROY, 9'd1, res);                 // tracked: freed
        send_item(MODE_DESTROY, 9'd1, res);                 // count now zero
        send_item(MODE_DESTROY, ID_W'(LOW_CAP), res);       // beyond tracked range
        send_item(MODE_DESTROY, ID_W'(ID_MAX), res);
        send_item(MODE_RELEASE, 9'd257, res);
        send_item(MODE_FETCH_HIGH, '0, res);                // reuses 257
        send_item(MODE_FETCH_LOW, '0, res);                 // reuses 1, slow path
        send_item(MODE_RELEASE, '0, res);
        send_item(MODE_RELEASE, ID_W'(ID_MAX), res);
        send_item(MODE_FETCH_LOW, '0, res);
        // undefined modes echo body_id and change nothing
        for (int m = MODE_SOFT_RESET + 1; m < 2 ** MODE_W; m++)
            send_item(MODE_W'(m), ID_W'($urandom_range(0, ID_MAX)), res);
        send_item(MODE_SOFT_RESET, 9'h0AA, res);
        send_item(MODE_FETCH_LOW, 9'h155, res);             // counters cleared
        send_item(MODE_DESTROY, '0, res);                   // tracked count survived
    endtask

    // smallest limit, zero read as one, clamped maximum, limit lowered under
    // an id already sitting on the low stack
    task automatic test_limit_extremes();
        alloc_result_t res;
        program_limit(9'd1);
        send_item(MODE_SOFT_RESET, '0, res);
        send_item(MODE_FETCH_LOW, '0, res);
        send_item(MODE_FETCH_LOW, '0, res);                 // low pool empty
        send_item(MODE_FETCH_HIGH, '0, res);
        send_item(MODE_RELEASE, '0, res);
        send_item(MODE_FETCH_LOW, '0, res);
        program_limit('0);
        send_item(MODE_FETCH_LOW, '0, res);
        send_item(MODE_FETCH_HIGH, '0, res);
        send_item(MODE_RELEASE, 9'd1, res);                 // 1 is high pool here
        send_item(MODE_FETCH_HIGH, '0, res);
        program_limit(LIMIT_W'(ID_MAX));
        send_item(MODE_SOFT_RESET, '0, res);
        send_item(MODE_FETCH_LOW, '0, res);
        send_item(MODE_FETCH_HIGH, '0, res);
        send_item(MODE_RELEASE, 9'd200, res);
        program_limit(9'd2);
        send_item(MODE_FETCH_LOW, '0, res);                 // 200 handed out as is
        send_item(MODE_FETCH_HIGH, '0, res);
        program_limit(LIMIT_RESET);
    endtask

    // fill the low stack to the brim with one id, then take a few back out
    task automatic test_stack_full();
        alloc_result_t res;
        send_item(MODE_SOFT_RESET, '0, res);
        send_item(MODE_FETCH_LOW, '0, res);
        repeat (LOW_CAP)
            send_item(MODE_RELEASE, '0, res);
        send_item(MODE_RELEASE, '0, res);                   // stack full
        send_item(MODE_DESTROY, '0, res);                   // full, count kept
        repeat (2)
            send_item(MODE_FETCH_LOW, '0, res);
        send_item(MODE_DESTROY, '0, res);
    endtask

    // receiver holds off while items keep coming, so the block backs up
    task automatic test_backpressure();
        alloc_result_t res;
        tx_gap_pct      = 0;
        rx_hold_request = 200;
        repeat (16)
            send_item(MODE_W'($urandom_range(MODE_FETCH_LOW, MODE_RELEASE)),
                      ID_W'($urandom_range(0, ID_MAX)), res);
    endtask

    // Mostly well-formed traffic: ids that were handed out are later
    // destroyed or released; the rest is soft resets, undefined modes and
    // arbitrary ids. Each phase runs at its own limit and idling level.
    task automatic test_random_traffic();
        alloc_result_t   res;
        logic [ID_W-1:0] low_live  [$];
        logic [ID_W-1:0] high_live [$];
        logic [ID_W-1:0] id;
        int              phase_limits [10];
        int              sel;
        int              k;
        phase_limits    = '{256, 1, 0, 511, 300, 100, 257, 2, 64, 255};
        phase_limits[7] = $urandom_range(2, ID_MAX);
        for (int p = 0; p < 10; p++)
        begin
            program_limit(LIMIT_W'(phase_limits[p]));
            // first and seventh phase run without any idling
            tx_gap_pct   = (p == 0 || p == 6) ? 0 : $urandom_range(5, 50);
            rx_stall_pct = (p == 0 || p == 6) ? 0 : $urandom_range(5, 50);
            for (int n = 0; n < 14; n++)
            begin
                sel = $urandom_range(0, 99);
                id  = ID_W'($urandom_range(0, ID_MAX));
                if (sel < 28)
                begin
                    send_item(MODE_FETCH_LOW, id, res);
                    if (res.stat == STAT_OK)
                        low_live.insert(low_live.size(), res.rid);
                end
                else if (sel < 46)
                begin
                    send_item(MODE_FETCH_HIGH, id, res);
                    if (res.stat == STAT_OK)
                        high_live.insert(high_live.size(), res.rid);
                end
                else if (sel < 64)
                begin
                    if (low_live.size() != 0 && sel < 60)
                    begin
                        k  = $urandom_range(0, low_live.size() - 1);
                        id = low_live[k];
                        low_live.delete(k);
                    end
                    send_item(MODE_DESTROY, id, res);
                end
                else if (sel < 84)
                begin
                    if (high_live.size() != 0 && sel < 74)
                    begin
                        k  = $urandom_range(0, high_live.size() - 1);
                        id = high_live[k];
                        high_live.delete(k);
                    end
                    else if (low_live.size() != 0 && sel < 81)
                    begin
                        k  = $urandom_range(0, low_live.size() - 1);
                        id = low_live[k];
                        low_live.delete(k);
                    end
                    send_item(MODE_RELEASE, id, res);
                end
                else if (sel < 88)
                begin
                    send_item(MODE_SOFT_RESET, id, res);
                    low_live.delete();
                    high_live.delete();
                end
                else if (sel < 92)
                    send_item(MODE_W'($urandom_range(MODE_SOFT_RESET + 1, 2 ** MODE_W - 1)),
                              id, res);
                else
                    send_item($urandom_range(0, 1) ? MODE_DESTROY : MODE_RELEASE, id, res);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        foreach (trk_count[i])
            trk_count[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        // block sweeps its tracked counts first; req_ready stays low meanwhile
        test_register_access();
        tx_gap_pct   = 30;
        rx_stall_pct = 30;
        test_basic_ops();
        test_limit_extremes();
        tx_gap_pct   = 10;
        rx_stall_pct = 10;
        test_stack_full();
        test_backpressure();
        test_random_traffic();
        wait_idle();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
